// ===== src/lps_pkg.sv =====
// Shared constants and helpers for the line pixel stepper.
package lps_pkg;

    localparam int COORD_BITS_DEFAULT  = 11;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Request operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Line cases: bit 1 set means the walk runs along y.
    localparam logic [1:0] CASE_SHALLOW_UP    = 2'd0;
    localparam logic [1:0] CASE_SHALLOW_DOWN  = 2'd1;
    localparam logic [1:0] CASE_STEEP_RIGHT   = 2'd2;
    localparam logic [1:0] CASE_STEEP_LEFT    = 2'd3;

    // Width of one queue entry: operation, case, three coordinates,
    // the error term and the two doubled increments.
    function automatic int entry_bits(input int coord_bits);
        return 6 * coord_bits + 10;
    endfunction

endpackage

// ===== src/lps_cmd_if.sv =====
// Request channel carrying the operation and the two line endpoints.
interface lps_cmd_if #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (
        output valid, operation, x_start, y_start, x_end, y_end,
        input  ready
    );

    modport sink (
        input  valid, operation, x_start, y_start, x_end, y_end,
        output ready
    );
endinterface

// ===== src/lps_pix_if.sv =====
// Result channel carrying one plotted pixel and its last flag.
interface lps_pix_if #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, last_pixel,
        output ready
    );
endinterface

// ===== src/line_pixel_stepper_unit.sv =====
// A step request passes through the request queue and then the registered output stage before its pixel appears.
// Throughput: one request per cycle unless the queue is full or the pixel output is held by back-pressure;
// each step is one add, compare and increment in the back end. A start request takes one queue slot, loads
// the walk state in the back end and gives no pixel. Reset (rst_n low, asynchronous) clears the queue,
// the walk state and the output; the unit is idle. Top level: front end, request queue and back end.
module line_pixel_stepper_unit #(
    parameter int COORD_BITS  = lps_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = lps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    lps_cmd_if.sink    cmd,
    lps_pix_if.source  pix
);

    localparam int ENTRY_BITS = lps_pkg::entry_bits(COORD_BITS);

    logic                  queue_full;
    logic                  push;
    logic [ENTRY_BITS-1:0] push_entry;
    logic                  pop;
    logic                  head_valid;
    logic [ENTRY_BITS-1:0] head_entry;

    lps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .cmd        (cmd),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    lps_queue #(
        .DATA_BITS (ENTRY_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_entry)
    );

    lps_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .pix        (pix)
    );

endmodule

// ===== src/lps_front.sv =====
// Front end: accepts requests and works out the line set-up for starts.
module lps_front #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
    lps_cmd_if.sink                                       cmd,
    input  logic                                          queue_full,
    output logic                                          push,
    output logic [lps_pkg::entry_bits(COORD_BITS)-1:0]    push_entry
);

    typedef struct packed {
        logic                    operation;
        logic [1:0]              line_case;
        logic [COORD_BITS-1:0]   cur_x;
        logic [COORD_BITS-1:0]   cur_y;
        logic [COORD_BITS-1:0]   major_end;
        logic [COORD_BITS+2:0]   error_term;
        logic [COORD_BITS+1:0]   minor_inc;
        logic [COORD_BITS+1:0]   major_inc;
    } lps_entry_t;

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;
    logic                         shallow;
    logic                         swap;
    logic                         minor_neg;
    logic        [COORD_BITS-1:0] dmaj;
    logic        [COORD_BITS-1:0] dmin;
    lps_entry_t                   entry;

    assign cmd.ready = !queue_full;
    assign push      = cmd.valid && !queue_full;

    always_comb
    begin
        dx  = $signed({1'b0, cmd.x_end}) - $signed({1'b0, cmd.x_start});
        dy  = $signed({1'b0, cmd.y_end}) - $signed({1'b0, cmd.y_start});
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        shallow = (ady <= adx);

        // The walk always runs upward along the major axis, so a line drawn
        // the other way is taken from its far end; the minor delta flips sign.
        if (shallow)
        begin
            swap      = dx[COORD_BITS];
            minor_neg = (dy != '0) && (dy[COORD_BITS] ^ swap);
            dmaj      = adx;
            dmin      = ady;
        end
        else
        begin
            swap      = dy[COORD_BITS];
            minor_neg = (dx != '0) && (dx[COORD_BITS] ^ swap);
            dmaj      = ady;
            dmin      = adx;
        end

        entry.operation = cmd.operation;
        if (shallow)
        begin
            entry.line_case = minor_neg ? lps_pkg::CASE_SHALLOW_DOWN
                                        : lps_pkg::CASE_SHALLOW_UP;
            entry.major_end = swap ? cmd.x_start : cmd.x_end;
        end
        else
        begin
            entry.line_case = minor_neg ? lps_pkg::CASE_STEEP_LEFT
                                        : lps_pkg::CASE_STEEP_RIGHT;
            entry.major_end = swap ? cmd.y_start : cmd.y_end;
        end
        entry.cur_x      = swap ? cmd.x_end : cmd.x_start;
        entry.cur_y      = swap ? cmd.y_end : cmd.y_start;
        entry.minor_inc  = {1'b0, dmin, 1'b0};
        entry.major_inc  = {1'b0, dmaj, 1'b0};
        entry.error_term = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
    end

    assign push_entry = entry;

endmodule

// ===== src/lps_queue.sv =====
// Short first-in first-out queue between the front and back ends.
module lps_queue #(
    parameter int DATA_BITS = 16,
    parameter int DEPTH     = lps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output logic [DATA_BITS-1:0] head_data
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0]  store_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    assign full       = (count_reg == COUNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ===== src/lps_back.sv =====
// Back end: holds the walk state, steps one pixel per step request while a line is active and registers it.
module lps_back #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       head_valid,
    input  logic [lps_pkg::entry_bits(COORD_BITS)-1:0] head_entry,
    output logic                                       pop,
    lps_pix_if.source                                  pix
);

    typedef struct packed {
        logic                    operation;
        logic [1:0]              line_case;
        logic [COORD_BITS-1:0]   cur_x;
        logic [COORD_BITS-1:0]   cur_y;
        logic [COORD_BITS-1:0]   major_end;
        logic [COORD_BITS+2:0]   error_term;
        logic [COORD_BITS+1:0]   minor_inc;
        logic [COORD_BITS+1:0]   major_inc;
    } lps_entry_t;

    lps_entry_t              head;

    logic                    busy_reg;
    logic                    busy_next;
    logic [1:0]              line_case_reg;
    logic [1:0]              line_case_next;
    logic [COORD_BITS-1:0]   cur_x_reg;
    logic [COORD_BITS-1:0]   cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg;
    logic [COORD_BITS-1:0]   cur_y_next;
    logic [COORD_BITS-1:0]   major_end_reg;
    logic [COORD_BITS-1:0]   major_end_next;
    logic [COORD_BITS+2:0]   error_reg;
    logic [COORD_BITS+2:0]   error_next;
    logic [COORD_BITS+1:0]   minor_inc_reg;
    logic [COORD_BITS+1:0]   minor_inc_next;
    logic [COORD_BITS+1:0]   major_inc_reg;
    logic [COORD_BITS+1:0]   major_inc_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [COORD_BITS-1:0]   out_x_reg;
    logic [COORD_BITS-1:0]   out_y_reg;
    logic                    out_last_reg;

    logic                    out_free;
    logic                    is_step;
    logic                    result_load;
    logic                    steep;
    logic                    last;
    logic                    error_pos;
    logic [COORD_BITS-1:0]   minor_x;
    logic [COORD_BITS-1:0]   minor_y;

    assign head = head_entry;

    // The output register may be refilled in the cycle its pixel is taken.
    assign out_free    = !out_valid_reg || pix.ready;
    assign is_step     = (head.operation == lps_pkg::OP_STEP);
    assign pop         = head_valid && (!is_step || !busy_reg || out_free);
    assign result_load = pop && is_step && busy_reg;

    assign steep     = line_case_reg[1];
    assign last      = ((steep ? cur_y_reg : cur_x_reg) == major_end_reg);
    assign error_pos = !error_reg[COORD_BITS+2] && (error_reg != '0);

    always_comb
    begin
        minor_x = cur_x_reg;
        minor_y = cur_y_reg;
        if (error_pos)
        begin
            unique case (line_case_reg)
                lps_pkg::CASE_SHALLOW_UP:   minor_y = cur_y_reg + 1'b1;
                lps_pkg::CASE_SHALLOW_DOWN: minor_y = cur_y_reg - 1'b1;
                lps_pkg::CASE_STEEP_RIGHT:  minor_x = cur_x_reg + 1'b1;
                lps_pkg::CASE_STEEP_LEFT:   minor_x = cur_x_reg - 1'b1;
                default:                    minor_x = cur_x_reg;
            endcase
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        line_case_next = line_case_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        error_next     = error_reg;
        minor_inc_next = minor_inc_reg;
        major_inc_next = major_inc_reg;

        if (pop && !is_step)
        begin
            busy_next      = 1'b1;
            line_case_next = head.line_case;
            cur_x_next     = head.cur_x;
            cur_y_next     = head.cur_y;
            major_end_next = head.major_end;
            error_next     = head.error_term;
            minor_inc_next = head.minor_inc;
            major_inc_next = head.major_inc;
        end
        else if (result_load)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                error_next = error_reg + {1'b0, minor_inc_reg}
                             - (error_pos ? {1'b0, major_inc_reg} : '0);
                cur_x_next = steep ? minor_x : minor_x + 1'b1;
                cur_y_next = steep ? minor_y + 1'b1 : minor_y;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            line_case_reg <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            major_end_reg <= '0;
            error_reg     <= '0;
            minor_inc_reg <= '0;
            major_inc_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            line_case_reg <= line_case_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            major_end_reg <= major_end_next;
            error_reg     <= error_next;
            minor_inc_reg <= minor_inc_next;
            major_inc_reg <= major_inc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_x_reg    <= cur_x_reg;
            out_y_reg    <= cur_y_reg;
            out_last_reg <= last;
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.pixel_x    = out_x_reg;
    assign pix.pixel_y    = out_y_reg;
    assign pix.last_pixel = out_last_reg;

`ifndef SYNTH
    a_result_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> busy_reg && out_free)
        else $error("pixel produced without an active line or a free slot");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && last) |=> !busy_reg && out_valid_reg && pix.last_pixel)
        else $error("final pixel did not end the line");

    a_increments_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        minor_inc_reg <= major_inc_reg)
        else $error("minor increment exceeds major increment");
`endif

endmodule
